/* design/positional_list_engine_defines.svh */
// Assertion macros for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_list_engine: same-cycle check failed");
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_list_engine: next-cycle check failed");
`else
`define PLE_ASSERT_NOW(label, ante, cons)
`define PLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/ple_pkg.sv */
package ple_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VAL_W         = 32;
    localparam int POS_W         = 5;
    localparam int FIDX_W        = 4;
    localparam int CNT_W         = 5;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_REAR  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_COUNT     = 3'd7
    } op_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BADPOS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_e;

    typedef struct packed {
        op_e                     op;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } ple_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [FIDX_W-1:0] found_index;
        logic [CNT_W-1:0]  entry_count;
    } ple_rsp_t;

    typedef struct packed {
        logic ins;
        logic del;
    } ple_cmd_t;

endpackage

/* design/ple_cell.sv */
module ple_cell
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int INDEX = 0,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                    clk,
    input  ple_cmd_t                cmd,
    input  logic [CW-1:0]           pos,
    input  logic [CW-1:0]           count,
    input  logic signed [VAL_W-1:0] key,
    input  logic signed [VAL_W-1:0] left,
    input  logic signed [VAL_W-1:0] right,
    output logic signed [VAL_W-1:0] value,
    output logic                    match
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (IDX > pos)
                value_next = left;
            else if (IDX == pos)
                value_next = key;
        end
        else if (cmd.del)
        begin
            if (IDX >= pos)
                value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key) && (IDX < count);

endmodule

/* design/ple_locate.sv */
module ple_locate
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0] match,
    output logic             hit,
    output logic [IW-1:0]    index
);

    always_comb
    begin
        index = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
                index = IW'(i);
        end
    end

    assign hit = |match;

endmodule

/* design/positional_list_engine.sv */
// The result item is registered at the edge that accepts the request.
// Throughput: one request per cycle while req_stall is low; all entry cells shift and compare in parallel.
// req_stall is high only while a registered result is held by rsp_stall.
// Reset (rst_n low, asynchronous) empties the list and drops any pending result;
// entry cells are not cleared and are read only below the entry count.
`include "positional_list_engine_defines.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  ple_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ple_rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int EW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    ple_rsp_t      rsp_reg;
    ple_rsp_t      rsp_next;

    logic          accept;
    ple_cmd_t      cmd;
    logic [CW-1:0] at_pos;
    status_e       status;
    logic [EW-1:0] pos_ext;
    logic [EW-1:0] cnt_ext;
    logic          empty;
    logic          full;

    logic signed [VAL_W-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]        match;
    logic                    hit;
    logic [IW-1:0]           hit_index;

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    assign pos_ext = EW'(req.position);
    assign cnt_ext = EW'(count_reg);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);

    always_comb
    begin
        cmd        = '0;
        at_pos     = '0;
        status     = ST_OK;
        count_next = count_reg;
        case (req.op)
            OP_INS_FRONT, OP_INS_REAR, OP_INS_AT:
            begin
                if (req.op == OP_INS_REAR)
                    at_pos = count_reg;
                else if (req.op == OP_INS_AT)
                    at_pos = CW'(req.position);
                if (req.op == OP_INS_AT && pos_ext > cnt_ext)
                    status = ST_BADPOS;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_AT:
            begin
                if (req.op == OP_DEL_REAR)
                    at_pos = count_reg - CW'(1);
                else if (req.op == OP_DEL_AT)
                    at_pos = CW'(req.position);
                if (empty)
                    status = ST_EMPTY;
                else if (req.op == OP_DEL_AT && pos_ext >= cnt_ext)
                    status = ST_BADPOS;
                else
                begin
                    cmd.del    = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            OP_SEARCH:
            begin
                status = hit ? ST_OK : ST_NOT_FOUND;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.status      = status;
        rsp_next.found_index = (req.op == OP_SEARCH && hit) ? FIDX_W'(hit_index) : '0;
        rsp_next.entry_count = CNT_W'(count_next);
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = req.value;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_val = cell_val[g];
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        ple_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .pos   (at_pos),
            .count (count_reg),
            .key   (req.value),
            .left  (left_val),
            .right (right_val),
            .value (cell_val[g]),
            .match (match[g])
        );
    end

    ple_locate #(
        .DEPTH (DEPTH)
    ) u_locate (
        .match (match),
        .hit   (hit),
        .index (hit_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `PLE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    `PLE_ASSERT_NEXT(a_ins_grows, cmd.ins, count_reg == $past(count_reg) + CW'(1))
    `PLE_ASSERT_NEXT(a_del_shrinks, cmd.del, count_reg == $past(count_reg) - CW'(1))
    `PLE_ASSERT_NOW(a_hit_in_list, accept && req.op == OP_SEARCH && hit,
        CW'(hit_index) < count_reg)
    `PLE_ASSERT_NOW(a_full_only_at_depth, accept && status == ST_FULL, full)

endmodule
